>>> hdl/ptt_pkg.sv
package ptt_pkg;

  localparam int MAX_TASKS_DEF = 8;

  localparam int OPCODE_W   = 3;
  localparam int ID_W       = 3;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int MASK_W     = 8;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INTERVAL = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ENABLE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FORCE    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADID = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_t;

endpackage

>>> hdl/ptt_slot_mem.sv
module ptt_slot_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                      clk,
  input  logic                      wr_iv_en,
  input  logic                      wr_lt_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ptt_pkg::TIME_W-1:0] wr_iv_data,
  input  logic [ptt_pkg::TIME_W-1:0] wr_lt_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [ptt_pkg::TIME_W-1:0] rd_iv,
  output logic [ptt_pkg::TIME_W-1:0] rd_lt
);
  import ptt_pkg::*;

  logic [TIME_W-1:0] iv_mem [DEPTH];
  logic [TIME_W-1:0] lt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_iv_en) begin
      iv_mem[wr_addr] <= wr_iv_data;
    end
    if (wr_lt_en) begin
      lt_mem[wr_addr] <= wr_lt_data;
    end
    rd_iv <= iv_mem[rd_addr];
    rd_lt <= lt_mem[rd_addr];
  end

endmodule

>>> hdl/periodic_task_timer_table.sv
// channel | direction | ports                                            | handshake
// input   | in        | in_opcode in_task_id in_interval_ms in_enable     | in_valid/in_ready
//         |           | in_now_ms                                         |
// result  | out       | out_status out_assigned_id out_fired_mask         | out_valid/out_ready
//
// add, change interval, set enable and unused opcodes go from S_IDLE straight to S_DONE;
// force passes S_READ and S_EXEC (slot read from the memory, one pass through the
// subtractor); dispatch passes S_READ, then S_EXEC once per task in use, one slot a cycle
// through the shared subtract/compare unit, and goes straight to S_DONE on an empty table.
// rst_n (synchronous) empties the table and clears all enables; slot memories are not cleared.
// one item at a time: in_ready is high only when idle; a new word is taken while
// the previous result still waits in the output register, and its result waits
// in turn until that register is free.
module periodic_task_timer_table #(
  parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptt_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ptt_pkg::ID_W-1:0]      in_task_id,
  input  logic [ptt_pkg::TIME_W-1:0]    in_interval_ms,
  input  logic                          in_enable,
  input  logic [ptt_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptt_pkg::STATUS_W-1:0]  out_status,
  output logic [ptt_pkg::ID_W-1:0]      out_assigned_id,
  output logic [ptt_pkg::MASK_W-1:0]    out_fired_mask
);
  import ptt_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int FW    = (IDX_W > 4) ? IDX_W : 4;

  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] en_r, en_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic [OPCODE_W-1:0]  op_r, op_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;

  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic [MASK_W-1:0]    res_mask_r, res_mask_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [MASK_W-1:0]    out_mask_r, out_mask_nxt;

  logic                 wr_iv_en, wr_lt_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [TIME_W-1:0]    wr_iv_data, wr_lt_data;
  logic [TIME_W-1:0]    rd_iv, rd_lt;

  logic [TIME_W-1:0]    sub_opnd, sub_res;
  logic                 due;
  logic                 id_ok, accept, last_slot;
  logic [FW-1:0]        idx_wide;
  logic [CMP_W-1:0]     count_wide;

  ptt_slot_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (IDX_W)
  ) u_mem (
    .clk        (clk),
    .wr_iv_en   (wr_iv_en),
    .wr_lt_en   (wr_lt_en),
    .wr_addr    (wr_addr),
    .wr_iv_data (wr_iv_data),
    .wr_lt_data (wr_lt_data),
    .rd_addr    (rd_addr),
    .rd_iv      (rd_iv),
    .rd_lt      (rd_lt)
  );

  // shared subtract/compare unit: force uses now - interval, dispatch now - last
  assign sub_opnd = (op_r == OP_FORCE) ? rd_iv : rd_lt;
  assign sub_res  = now_r - sub_opnd;
  assign due      = en_r[idx_r] && (sub_res >= rd_iv);

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign id_ok      = CMP_W'(in_task_id) < CMP_W'(count_r);
  assign last_slot  = (CNT_W'(idx_r) + CNT_W'(1)) >= count_r;
  assign idx_wide   = FW'(idx_r);
  assign count_wide = CMP_W'(count_r);

  // next slot is fetched while the current one is checked
  assign rd_addr = (state_r == S_EXEC) ? idx_r + IDX_W'(1) : idx_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    en_nxt         = en_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_mask_nxt   = res_mask_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_mask_nxt   = out_mask_r;
    wr_iv_en       = 1'b0;
    wr_lt_en       = 1'b0;
    wr_addr        = idx_r;
    wr_iv_data     = in_interval_ms;
    wr_lt_data     = in_now_ms;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_opcode;
          now_nxt        = in_now_ms;
          res_status_nxt = ST_DONE;
          res_id_nxt     = '0;
          res_mask_nxt   = '0;
          idx_nxt        = '0;
          state_nxt      = S_DONE;
          case (in_opcode)
            OP_ADD: begin
              if (count_r >= CNT_W'(MAX_TASKS)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_addr                      = count_r[IDX_W-1:0];
                wr_iv_en                     = 1'b1;
                wr_lt_en                     = 1'b1;
                en_nxt[count_r[IDX_W-1:0]]   = 1'b1;
                count_nxt                    = count_r + CNT_W'(1);
                res_id_nxt                   = count_wide[ID_W-1:0];
              end
            end
            OP_INTERVAL, OP_ENABLE, OP_FORCE: begin
              if (!id_ok) begin
                res_status_nxt = ST_BADID;
              end else begin
                wr_addr = IDX_W'(in_task_id);
                if (in_opcode == OP_INTERVAL) begin
                  wr_iv_en = 1'b1;
                end else if (in_opcode == OP_ENABLE) begin
                  en_nxt[IDX_W'(in_task_id)] = in_enable;
                  wr_lt_en                   = in_enable;
                end else begin
                  idx_nxt   = IDX_W'(in_task_id);
                  state_nxt = S_READ;
                end
              end
            end
            OP_DISPATCH: begin
              if (count_r != '0) begin
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (op_r == OP_FORCE) begin
          wr_lt_en   = 1'b1;
          wr_lt_data = sub_res;
          state_nxt  = S_DONE;
        end else begin
          if (due) begin
            wr_lt_en   = 1'b1;
            wr_lt_data = now_r;
            if (idx_wide < FW'(MASK_W)) begin
              res_mask_nxt[idx_wide[2:0]] = 1'b1;
            end
          end
          if (last_slot) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_mask_nxt   = res_mask_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    now_r        <= now_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_mask_r   <= res_mask_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_mask_r   <= out_mask_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_id_r;
  assign out_fired_mask  = out_mask_r;

endmodule
